// ===== src/msc_pkg.sv =====
package msc_pkg;

  localparam int LANES       = 8;
  localparam int DATA_WIDTH  = 32;
  localparam int TOTAL_WIDTH = 32;
  localparam int LANE_W      = $clog2(LANES);
  localparam int CNT_W       = $clog2(LANES + 1);
  localparam int BUF_DEPTH   = 2 * LANES - 1;
  localparam int BUF_IW      = $clog2(BUF_DEPTH + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0]  word_t;
  typedef logic [TOTAL_WIDTH-1:0] total_t;
  typedef logic [LANES-1:0][DATA_WIDTH-1:0] word_vec_t;

  typedef struct packed {
    word_t            word0;
    word_t            word1;
    word_t            word2;
    word_t            word3;
    word_t            word4;
    word_t            word5;
    word_t            word6;
    word_t            word7;
    logic [LANES-1:0] keep_mask;
    logic             final_beat;
  } in_beat_t;

  typedef struct packed {
    word_t            packed0;
    word_t            packed1;
    word_t            packed2;
    word_t            packed3;
    word_t            packed4;
    word_t            packed5;
    word_t            packed6;
    word_t            packed7;
    logic [CNT_W-1:0] word_count;
    logic             stream_end;
    total_t           selected_total;
  } out_beat_t;

  // Result beats produced by one input beat, in delivery order.
  typedef struct packed {
    logic first_vld;
    logic second_vld;
  } push_ctrl_t;

  function automatic word_vec_t beat_words(in_beat_t b);
    word_vec_t w;
    w[0] = b.word0;
    w[1] = b.word1;
    w[2] = b.word2;
    w[3] = b.word3;
    w[4] = b.word4;
    w[5] = b.word5;
    w[6] = b.word6;
    w[7] = b.word7;
    return w;
  endfunction

  function automatic out_beat_t make_beat(word_vec_t w, logic [CNT_W-1:0] cnt,
                                          logic last, total_t total);
    out_beat_t b;
    b.packed0        = w[0];
    b.packed1        = w[1];
    b.packed2        = w[2];
    b.packed3        = w[3];
    b.packed4        = w[4];
    b.packed5        = w[5];
    b.packed6        = w[6];
    b.packed7        = w[7];
    b.word_count     = cnt;
    b.stream_end     = last;
    b.selected_total = total;
    return b;
  endfunction

endpackage

// ===== src/msc_compact.sv =====
module msc_compact (
  input  msc_pkg::word_vec_t             words,
  input  logic [msc_pkg::LANES-1:0]      keep,
  output msc_pkg::word_vec_t             comp,
  output logic [msc_pkg::CNT_W-1:0]      kept
);
  import msc_pkg::*;

  logic [LANES-1:0][CNT_W-1:0] pos;

  // Each kept lane lands at the number of kept lanes below it.
  always_comb begin
    logic [CNT_W-1:0] run;
    run = '0;
    for (int i = 0; i < LANES; i++) begin
      pos[i] = run;
      run    = run + CNT_W'(keep[i]);
    end
    kept = run;
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      comp[j] = '0;
      for (int i = 0; i < LANES; i++) begin
        if (keep[i] && (pos[i] == CNT_W'(j))) begin
          comp[j] = comp[j] | words[i];
        end
      end
    end
  end

endmodule

// ===== src/msc_merge.sv =====
module msc_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  msc_pkg::word_vec_t          comp,
  input  logic [msc_pkg::CNT_W-1:0]   kept,
  input  logic                        last,
  output msc_pkg::push_ctrl_t         push,
  output msc_pkg::out_beat_t          first_beat,
  output msc_pkg::out_beat_t          second_beat
);
  import msc_pkg::*;

  word_t                   pend_words [LANES-1];
  logic [LANE_W-1:0]       pend_count;
  total_t                  total;

  word_t                   buf_words [BUF_DEPTH];
  word_t                   rem_words [LANES-1];
  logic [BUF_IW-1:0]       sum;
  logic                    full;
  logic [LANE_W-1:0]       rem;
  logic [TOTAL_WIDTH:0]    total_sum;
  total_t                  total_next;
  word_vec_t               full_vec;
  word_vec_t               flush_vec;
  out_beat_t               full_beat;
  out_beat_t               flush_beat;

  // Pending words first, then the newly compacted words behind them.
  always_comb begin
    logic [BUF_IW-1:0] d;
    for (int k = 0; k < BUF_DEPTH; k++) begin
      d = BUF_IW'(k) - BUF_IW'(pend_count);
      if (BUF_IW'(k) < BUF_IW'(pend_count)) begin
        buf_words[k] = pend_words[k];
      end else if (d < BUF_IW'(LANES)) begin
        buf_words[k] = comp[d[LANE_W-1:0]];
      end else begin
        buf_words[k] = '0;
      end
    end
  end

  assign sum  = BUF_IW'(pend_count) + BUF_IW'(kept);
  assign full = (sum >= BUF_IW'(LANES));
  assign rem  = full ? LANE_W'(sum - BUF_IW'(LANES)) : LANE_W'(sum);

  always_comb begin
    for (int j = 0; j < LANES - 1; j++) begin
      rem_words[j] = full ? buf_words[j + LANES] : buf_words[j];
    end
  end

  assign total_sum  = {1'b0, total} + (TOTAL_WIDTH + 1)'(kept);
  assign total_next = total_sum[TOTAL_WIDTH] ? '1 : total_sum[TOTAL_WIDTH-1:0];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      full_vec[j] = buf_words[j];
      if (j < LANES - 1 && LANE_W'(j) < rem) begin
        flush_vec[j] = rem_words[j];
      end else begin
        flush_vec[j] = '0;
      end
    end
  end

  assign full_beat  = make_beat(full_vec, CNT_W'(LANES), 1'b0, total_next);
  assign flush_beat = make_beat(flush_vec, CNT_W'(rem), 1'b1, total_next);

  assign push.first_vld  = take && (full || last);
  assign push.second_vld = take && full && last;
  assign first_beat      = full ? full_beat : flush_beat;
  assign second_beat     = flush_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_count <= '0;
      total      <= '0;
    end else if (take) begin
      pend_count <= last ? '0 : rem;
      total      <= last ? '0 : total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int j = 0; j < LANES - 1; j++) begin
        pend_words[j] <= rem_words[j];
      end
    end
  end

endmodule

// ===== src/msc_queue.sv =====
module msc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  msc_pkg::push_ctrl_t  push,
  input  msc_pkg::out_beat_t   first_beat,
  input  msc_pkg::out_beat_t   second_beat,
  output logic                 room,
  output logic                 dst_valid,
  input  logic                 dst_ready,
  output msc_pkg::out_beat_t   dst_beat
);
  import msc_pkg::*;

  out_beat_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QCNT_W-1:0]    count;
  logic [QCNT_W-1:0]    n_push;
  logic                 pop;

  assign n_push    = QCNT_W'(push.first_vld) + QCNT_W'(push.second_vld);
  assign pop       = dst_valid && dst_ready;
  assign dst_valid = (count != '0);
  assign dst_beat  = entries[rd_ptr];
  // Room for the two beats that one input beat can produce at most.
  assign room      = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_push);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + n_push - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.first_vld) begin
      entries[wr_ptr] <= first_beat;
    end
    if (push.second_vld) begin
      entries[wr_ptr + QPTR_W'(1)] <= second_beat;
    end
  end

endmodule

// ===== src/masked_stream_compaction.sv =====
// Channel  Handshake              Payload     Carries
// src      src_valid/src_ready    src_beat    eight lane words, keep mask, final flag
// dst      dst_valid/dst_ready    dst_beat    eight packed words, count, end, total
//
// One source beat is accepted every cycle while results drain at the same pace.
// A beat is held in the input register and is then compacted, merged with the
// pending words and written to a four-entry result queue, from which results
// show at dst. A final beat that also completes a full beat posts two results,
// and the single dst port sets the pace at one result per cycle while dst_ready
// is high. Reset clears the input register valid, the pending count, the running
// total and the queue pointers. A stall at dst fills the queue, and src_ready falls
// once fewer than two queue entries remain free while a beat waits in the register.
module masked_stream_compaction (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_ready,
  input  msc_pkg::in_beat_t   src_beat,
  output logic                dst_valid,
  input  logic                dst_ready,
  output msc_pkg::out_beat_t  dst_beat
);
  import msc_pkg::*;

  // Input register stage.
  logic         in_vld;
  in_beat_t     in_beat;
  logic         room;
  logic         advance;

  word_vec_t    comp;
  logic [CNT_W-1:0] kept;
  push_ctrl_t   push;
  out_beat_t    first_beat;
  out_beat_t    second_beat;

  // The held beat moves on whenever the queue can absorb both of its results.
  assign advance   = in_vld && room;
  assign src_ready = !in_vld || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (src_valid && src_ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      in_beat <= src_beat;
    end
  end

  // Kept lanes are squeezed together in lane order.
  msc_compact u_compact (
    .words (beat_words(in_beat)),
    .keep  (in_beat.keep_mask),
    .comp  (comp),
    .kept  (kept)
  );

  // Pending buffer, running total, and formation of full and flush beats.
  msc_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .take        (advance),
    .comp        (comp),
    .kept        (kept),
    .last        (in_beat.final_beat),
    .push        (push),
    .first_beat  (first_beat),
    .second_beat (second_beat)
  );

  // Result queue decouples the dst handshake from the compaction stage.
  msc_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .first_beat  (first_beat),
    .second_beat (second_beat),
    .room        (room),
    .dst_valid   (dst_valid),
    .dst_ready   (dst_ready),
    .dst_beat    (dst_beat)
  );

endmodule

// ===== src/msc_checker.sv =====
module msc_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                dst_valid,
  input  logic                dst_ready,
  input  msc_pkg::out_beat_t  dst_beat
);
  import msc_pkg::*;

  // A stalled result beat holds.
  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_beat))
    else $error("dst beat changed while stalled");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("dst valid after reset");

  // Only a flush carries a partial beat, and a flush is never full.
  a_partial_is_flush: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> ((dst_beat.word_count == CNT_W'(LANES)) != dst_beat.stream_end))
    else $error("word count and stream end disagree");

  // An empty flush carries zero in packed0.
  a_empty_flush_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_beat.word_count == '0 |-> dst_beat.packed0 == '0)
    else $error("empty flush carries data");

  // Within a stream the reported total never drops; only a stream end resets it.
  a_total_after_end: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_ready && !dst_beat.stream_end ##1 dst_valid
      |-> dst_beat.selected_total >= $past(dst_beat.selected_total))
    else $error("selected total dropped within a stream");

endmodule

bind masked_stream_compaction msc_checker u_msc_checker (.*);

// ===== bench/masked_stream_compaction_tb.sv =====
module masked_stream_compaction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msc_pkg::*;

  // The run ends with a failure if it has not finished after this many cycles.
  // The slowest correct run is roughly 1700 beats, each with a long source gap
  // and two results that both wait out a long sink stall, and this limit is
  // several times the length of such a run.
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Random beats sent after the directed tests, every beat counted.
  localparam int RANDOM_BEATS  = 1625;
  // The settle time at the end is generous so that any stray result is still caught.
  localparam int SETTLE_CYCLES = 20;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  in_beat_t  src_beat  = '0;
  logic      dst_valid;
  logic      dst_ready = 1'b0;
  out_beat_t dst_beat;

  masked_stream_compaction dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_beat  (src_beat),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_beat  (dst_beat)
  );

  always #6 clk = ~clk;

  // Result beats that the block still owes us, oldest first.
  out_beat_t   owed_beats [$];

  // The predictor's own copy of the block's state. Words wait in carry_words
  // until eight of them have gathered. The stream total counts every kept word
  // since the last final beat.
  word_t       carry_words [LANES-1];
  int unsigned carry_count  = 0;
  total_t      stream_total = '0;

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Switches for the two kinds of idling. The tests turn them on and off, so
  // some stretches run with no gaps at all.
  bit          src_gaps_on   = 1'b0;
  bit          dst_stalls_on = 1'b0;

  // Most gaps and stalls are as short as they can be, others are longer, and a
  // few are long enough to fill the result queue of the block.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 1;
    else if (r < 95) return $urandom_range(2, 5);
    else return $urandom_range(10, 40);
  endfunction

  // Builds a result beat. Positions at or above the count read as zero.
  function automatic out_beat_t form_result(word_t src [2*LANES], int unsigned cnt,
                                            logic last, total_t tot);
    word_t     v [LANES];
    out_beat_t r;
    for (int j = 0; j < LANES; j++) v[j] = (j < cnt) ? src[j] : '0;
    r.packed0        = v[0];
    r.packed1        = v[1];
    r.packed2        = v[2];
    r.packed3        = v[3];
    r.packed4        = v[4];
    r.packed5        = v[5];
    r.packed6        = v[6];
    r.packed7        = v[7];
    r.word_count     = CNT_W'(cnt);
    r.stream_end     = last;
    r.selected_total = tot;
    return r;
  endfunction

  function automatic in_beat_t form_input(word_t w [LANES], logic [LANES-1:0] mask,
                                          logic last);
    in_beat_t b;
    b.word0      = w[0];
    b.word1      = w[1];
    b.word2      = w[2];
    b.word3      = w[3];
    b.word4      = w[4];
    b.word5      = w[5];
    b.word6      = w[6];
    b.word7      = w[7];
    b.keep_mask  = mask;
    b.final_beat = last;
    return b;
  endfunction

  // Works out the results of one accepted source beat. The kept words are
  // appended to the carried words in lane order. A full beat goes out as soon
  // as eight words are at hand, and a final beat then flushes whatever is left,
  // even if nothing is. The total saturates at its maximum. Saturation cannot
  // be reached in a run of this length, but the predictor still handles it.
  task automatic compact_beat(in_beat_t b);
    word_t           lane [LANES];
    word_t           gathered [2*LANES];
    int unsigned     have;
    int unsigned     kept;
    longint unsigned sum;
    lane[0] = b.word0;
    lane[1] = b.word1;
    lane[2] = b.word2;
    lane[3] = b.word3;
    lane[4] = b.word4;
    lane[5] = b.word5;
    lane[6] = b.word6;
    lane[7] = b.word7;
    have = carry_count;
    kept = 0;
    for (int j = 0; j < have; j++) gathered[j] = carry_words[j];
    for (int i = 0; i < LANES; i++) begin
      if (b.keep_mask[i]) begin
        gathered[have + kept] = lane[i];
        kept++;
      end
    end
    sum = longint'(stream_total) + kept;
    stream_total = (sum > 64'hFFFF_FFFF) ? '1 : total_t'(sum);
    have += kept;
    if (have >= LANES) begin
      owed_beats.push_back(form_result(gathered, LANES, 1'b0, stream_total));
      for (int j = LANES; j < have; j++) gathered[j - LANES] = gathered[j];
      have -= LANES;
    end
    if (b.final_beat) begin
      owed_beats.push_back(form_result(gathered, have, 1'b1, stream_total));
      carry_count  = 0;
      stream_total = '0;
    end else begin
      for (int j = 0; j < have; j++) carry_words[j] = gathered[j];
      carry_count = have;
    end
  endtask

  // Offers one beat from the next falling edge on and holds it until the block
  // takes it. Valid is left high afterwards. The next call or a pause decides
  // whether it stays high.
  task automatic send_beat(in_beat_t b);
    @(negedge clk);
    src_valid <= 1'b1;
    src_beat  <= b;
    do @(posedge clk); while (src_ready !== 1'b1);
    compact_beat(b);
  endtask

  task automatic pause_src(int unsigned cycles);
    @(negedge clk);
    src_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stops sending and waits until every owed result has come out.
  task automatic wait_drained();
    @(negedge clk);
    src_valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // The masks mix the edge shapes (all lanes, no lanes, one lane, all lanes
  // but one) with fully random ones.
  function automatic logic [LANES-1:0] rand_mask();
    logic [LANES-1:0] m;
    case ($urandom_range(0, 9))
      0: m = '1;
      1: m = '0;
      2: begin
        m = '0;
        m[$urandom_range(0, LANES - 1)] = 1'b1;
      end
      3: begin
        m = '1;
        m[$urandom_range(0, LANES - 1)] = 1'b0;
      end
      default: m = LANES'($urandom);
    endcase
    return m;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Every result beat that the sink accepts is compared with the oldest owed
  // beat, one field at a time.
  always @(posedge clk) begin
    if (!rst && dst_valid === 1'b1 && dst_ready) begin
      if (owed_beats.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat with nothing expected, actual %h", $time, dst_beat);
      end else begin
        check_field("packed0", owed_beats[0].packed0, dst_beat.packed0);
        check_field("packed1", owed_beats[0].packed1, dst_beat.packed1);
        check_field("packed2", owed_beats[0].packed2, dst_beat.packed2);
        check_field("packed3", owed_beats[0].packed3, dst_beat.packed3);
        check_field("packed4", owed_beats[0].packed4, dst_beat.packed4);
        check_field("packed5", owed_beats[0].packed5, dst_beat.packed5);
        check_field("packed6", owed_beats[0].packed6, dst_beat.packed6);
        check_field("packed7", owed_beats[0].packed7, dst_beat.packed7);
        check_field("word_count", 32'(owed_beats[0].word_count), 32'(dst_beat.word_count));
        check_field("stream_end", 32'(owed_beats[0].stream_end), 32'(dst_beat.stream_end));
        check_field("selected_total", owed_beats[0].selected_total,
                    dst_beat.selected_total);
        void'(owed_beats.pop_front());
      end
    end
  end

  // The sink stalls at random while stalls are switched on and is always ready
  // otherwise.
  initial begin : sink_driver
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        dst_ready <= 1'b0;
        hold--;
      end else if (dst_stalls_on && $urandom_range(0, 99) < 25) begin
        hold = idle_len() - 1;
        dst_ready <= 1'b0;
      end else begin
        dst_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Edge cases at stream boundaries. A full beat of all-ones words is followed
  // by a final beat with nothing left over, which still flushes an empty beat.
  // An empty beat that is not final gives nothing. A stream made of one empty
  // final beat reports a zero total. A full final beat gives both a full beat
  // and an empty flush.
  task automatic test_empty_flushes();
    word_t w [LANES];
    for (int i = 0; i < LANES; i++) w[i] = '1;
    send_beat(form_input(w, '1, 1'b0));
    for (int i = 0; i < LANES; i++) w[i] = '0;
    send_beat(form_input(w, '0, 1'b1));
    send_beat(form_input(w, '0, 1'b0));
    send_beat(form_input(w, '0, 1'b1));
    for (int i = 0; i < LANES; i++) w[i] = i[0] ? 32'hAAAA_AAAA : 32'h5555_5555;
    send_beat(form_input(w, '1, 1'b1));
    wait_drained();
  endtask

  // Fills the carry buffer to its seven-word limit one lane at a time, so
  // every lane lands in a different position. A full final beat then gives a
  // full beat and a seven-word flush. After that come two half masks that meet
  // at exactly eight words, and a one-word stream from the top lane.
  task automatic test_carry_limit();
    word_t            w [LANES];
    logic [LANES-1:0] m;
    for (int i = 0; i < LANES; i++) w[i] = 32'h0101_0101 * (i + 1);
    for (int i = 0; i < LANES - 1; i++) begin
      m = '0;
      m[i] = 1'b1;
      send_beat(form_input(w, m, 1'b0));
    end
    for (int i = 0; i < LANES; i++) w[i] = 32'hF0F0_0000 | 32'(i);
    send_beat(form_input(w, '1, 1'b1));
    send_beat(form_input(w, 8'h55, 1'b0));
    for (int i = 0; i < LANES; i++) w[i] = 32'h8000_0000 >> i;
    send_beat(form_input(w, 8'hAA, 1'b1));
    send_beat(form_input(w, 8'h80, 1'b1));
    wait_drained();
  endtask

  // Full beats go in back to back while the sink stalls at random, so the result
  // queue can fill and src_ready drop. Halfway through, the sender stops until
  // every owed result has come out, and then it finishes the stream.
  task automatic test_queue_backpressure();
    word_t w [LANES];
    dst_stalls_on = 1'b1;
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < LANES; i++) w[i] = rand_word();
      if (k == 4) wait_drained();
      send_beat(form_input(w, (k == 7) ? 8'h3C : '1, k == 7));
    end
    wait_drained();
    dst_stalls_on = 1'b0;
  endtask

  // Random streams of random length. Every stream ends in a final beat, and
  // most are short so that flushes come often. Each stream picks whether the
  // source has gaps and whether the sink stalls, so there are quiet stretches
  // as well as busy ones.
  task automatic test_random_streams();
    word_t            w [LANES];
    logic [LANES-1:0] m;
    int unsigned      counted;
    int unsigned      len;
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      len = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 30);
      src_gaps_on   = ($urandom_range(0, 3) != 0);
      dst_stalls_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len; k++) begin
        for (int i = 0; i < LANES; i++) w[i] = rand_word();
        m = rand_mask();
        send_beat(form_input(w, m, k == len - 1));
        counted++;
        if (src_gaps_on && $urandom_range(0, 99) < 30) pause_src(idle_len());
      end
    end
    wait_drained();
    src_gaps_on   = 1'b0;
    dst_stalls_on = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_flushes();
    test_carry_limit();
    test_queue_backpressure();
    test_random_streams();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
